// ===== rtl/mips_execute_alu_branch_macros.svh =====
// Assertion macros for the execute stage.
`ifndef MIPS_EXECUTE_ALU_BRANCH_MACROS_SVH
`define MIPS_EXECUTE_ALU_BRANCH_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MEAB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define MEAB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/meab_pkg.sv =====
// Types, opcodes and helpers shared by the execute stage modules.
`timescale 1ns / 1ps
package meab_pkg;

	localparam logic [3:0] OP_ADD  = 4'd0;
	localparam logic [3:0] OP_SUB  = 4'd1;
	localparam logic [3:0] OP_MULT = 4'd2;
	localparam logic [3:0] OP_DIV  = 4'd3;
	localparam logic [3:0] OP_LW   = 4'd4;
	localparam logic [3:0] OP_SW   = 4'd5;
	localparam logic [3:0] OP_ADDI = 4'd6;
	localparam logic [3:0] OP_BGTZ = 4'd7;
	localparam logic [3:0] OP_BLEZ = 4'd8;
	localparam logic [3:0] OP_BEQ  = 4'd9;
	localparam logic [3:0] OP_J    = 4'd10;

	localparam logic [1:0] ROUTE_FILE = 2'd1;
	localparam logic [1:0] ROUTE_MEM  = 2'd2;

	localparam int DIV_STAGES = 32;

	typedef struct packed {
		logic [3:0]         func;
		logic signed [31:0] rs_decoded;
		logic signed [31:0] rs_file_value;
		logic signed [31:0] rs_mem_value;
		logic [1:0]         rs_route;
		logic signed [31:0] rt_decoded;
		logic signed [31:0] rt_file_value;
		logic signed [31:0] rt_mem_value;
		logic [1:0]         rt_route;
		logic signed [31:0] immediate;
		logic               stall_two_ago;
		logic               bubble;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic signed [31:0] effective_address;
		logic               branch_taken;
		logic signed [31:0] branch_target;
		logic               divide_by_zero;
	} rsp_t;

	// Results that ride alongside the divider pipe.
	typedef struct packed {
		logic [31:0] res;
		logic [31:0] ea;
		logic        taken;
		logic [31:0] imm;
		logic        dz;
		logic        is_div;
		logic        neg;
	} side_t;

	function automatic logic [31:0] pick_operand(input logic [31:0] dec,
		input logic [31:0] file, input logic [31:0] mem, input logic [1:0] route,
		input logic stall2);
		logic [31:0] r;
		case (route)
			ROUTE_FILE: r = file;
			ROUTE_MEM:  r = stall2 ? file : mem;
			default:    r = dec;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/meab_div.sv =====
// Unsigned restoring divider, one quotient bit per pipeline stage, with sideband.
`timescale 1ns / 1ps
module meab_div
	import meab_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_v,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	input  side_t       side_in,
	output logic        out_v,
	output logic [31:0] quo,
	output side_t       side_out
);

	logic [31:0] rem_s [DIV_STAGES+1];
	logic [31:0] quo_s [DIV_STAGES+1];
	logic [31:0] dvs_s [DIV_STAGES+1];
	side_t       side_s [DIV_STAGES+1];
	logic        v_s [DIV_STAGES+1];

	assign rem_s[0]  = '0;
	assign quo_s[0]  = dividend;
	assign dvs_s[0]  = divisor;
	assign side_s[0] = side_in;
	assign v_s[0]    = in_v;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [31:0] shifted;
		logic        ge;
		assign shifted = {rem_s[k][30:0], quo_s[k][31]};
		assign ge      = shifted >= dvs_s[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? shifted - dvs_s[k] : shifted;
				quo_s[k+1]  <= {quo_s[k][30:0], ge};
				dvs_s[k+1]  <= dvs_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_v    = v_s[DIV_STAGES];
	assign quo      = quo_s[DIV_STAGES];
	assign side_out = side_s[DIV_STAGES];

endmodule

// ===== rtl/mips_execute_alu_branch.sv =====
// Top level of the pipelined MIPS execute stage with operand forwarding.
//
// Channels: req carries one instruction beat (req_valid / req_stall), rsp
// carries one result beat (rsp_valid / rsp_stall). A beat moves on a rising
// edge with valid high and stall low.
// Bubble beats are taken and dropped: they give no result beat.
// Throughput: one beat per cycle unless rsp is stalled with a beat waiting, every operation alike.
// Path from req beat to rsp valid: operand select (s1),
// ALU / multiply / sign prep (s2), 32 divider stages (one quotient bit each),
// then the output register. The divider depth sets the latency; all
// operations travel the same path so results leave in order.
// Stall: the whole pipe holds while rsp is stalled with a beat waiting;
// req_stall then goes high. Empty slots still fill while rsp is taken.
// Reset: all valid bits clear, saved branch target goes to 0.
// The saved target updates as a taken branch leaves the pipe, so
// branch_target reflects program order.
`timescale 1ns / 1ps
`include "mips_execute_alu_branch_macros.svh"
module mips_execute_alu_branch
	import meab_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic adv;
	assign adv       = !rsp_valid || !rsp_stall;
	assign req_stall = !adv;

	// s1: operand select
	logic        v_s1;
	logic [3:0]  func_s1;
	logic [31:0] rs_s1, rt_s1, imm_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid && !req.bubble;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= req.func;
			rs_s1   <= pick_operand(req.rs_decoded, req.rs_file_value, req.rs_mem_value,
				req.rs_route, req.stall_two_ago);
			rt_s1   <= pick_operand(req.rt_decoded, req.rt_file_value, req.rt_mem_value,
				req.rt_route, req.stall_two_ago);
			imm_s1  <= req.immediate;
		end
	end

	// s2: ALU, multiply, branch decision, divider operand prep
	side_t       side_c;
	logic [31:0] prod_c, mag_a_c, mag_b_c;

	assign prod_c  = 32'(rs_s1 * rt_s1);
	assign mag_a_c = rs_s1[31] ? 32'(0) - rs_s1 : rs_s1;
	assign mag_b_c = rt_s1[31] ? 32'(0) - rt_s1 : rt_s1;

	always_comb begin
		side_c        = '0;
		side_c.imm    = imm_s1;
		side_c.neg    = rs_s1[31] ^ rt_s1[31];
		case (func_s1)
			OP_ADD:  side_c.res = rs_s1 + rt_s1;
			OP_SUB:  side_c.res = rs_s1 - rt_s1;
			OP_MULT: side_c.res = prod_c;
			OP_DIV: begin
				side_c.is_div = 1'b1;
				side_c.dz     = rt_s1 == '0;
			end
			OP_LW, OP_SW: side_c.ea = rs_s1 + imm_s1;
			OP_ADDI: side_c.res   = rs_s1 + imm_s1;
			OP_BGTZ: side_c.taken = !rs_s1[31] && rs_s1 != '0;
			OP_BLEZ: side_c.taken = rs_s1[31] || rs_s1 == '0;
			OP_BEQ:  side_c.taken = rs_s1 == rt_s1;
			OP_J:    side_c.taken = 1'b1;
			default: side_c.res   = '0;
		endcase
	end

	logic        v_s2;
	side_t       side_s2;
	logic [31:0] mag_a_s2, mag_b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2  <= side_c;
			mag_a_s2 <= mag_a_c;
			mag_b_s2 <= mag_b_c;
		end
	end

	// divider pipe; non-divide results ride along as sideband
	logic        dv_v;
	logic [31:0] dv_quo;
	side_t       dv_side;

	meab_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_v     (v_s2),
		.dividend (mag_a_s2),
		.divisor  (mag_b_s2),
		.side_in  (side_s2),
		.out_v    (dv_v),
		.quo      (dv_quo),
		.side_out (dv_side)
	);

	// output register and saved target
	logic        rsp_valid_q;
	rsp_t        rsp_q;
	logic [31:0] saved_target_q;
	logic [31:0] fin_res;

	always_comb begin
		fin_res = dv_side.res;
		if (dv_side.is_div) begin
			if (dv_side.dz) begin
				fin_res = '0;
			end else begin
				fin_res = dv_side.neg ? 32'(0) - dv_quo : dv_quo;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q    <= 1'b0;
			saved_target_q <= '0;
		end else if (adv) begin
			rsp_valid_q <= dv_v;
			if (dv_v && dv_side.taken) begin
				saved_target_q <= dv_side.imm;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.result_value      <= fin_res;
			rsp_q.effective_address <= dv_side.ea;
			rsp_q.branch_taken      <= dv_side.taken;
			rsp_q.branch_target     <= dv_side.taken ? dv_side.imm : saved_target_q;
			rsp_q.divide_by_zero    <= dv_side.dz;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`MEAB_ASSERT_NOW(a_dz_clean, rsp_valid && rsp.divide_by_zero,
		rsp.result_value == 0 && !rsp.branch_taken && rsp.effective_address == 0,
		"divide by zero beat carries a result")
	`MEAB_ASSERT_NOW(a_stall_back, rsp_valid && rsp_stall, req_stall,
		"input taken while output blocked")
	`MEAB_ASSERT_NEXT(a_target_hold, !adv, $stable(saved_target_q),
		"saved target moved during stall")
	`MEAB_ASSERT_NOW(a_taken_target, rsp_valid && rsp.branch_taken,
		rsp.branch_target == saved_target_q,
		"taken branch target not latched")

endmodule

// ===== tb/sv/mips_execute_alu_branch_checker.sv =====
// Result checker for the execute stage: predicts each result beat and compares.
`timescale 1ns / 1ps
module mips_execute_alu_branch_checker
	import meab_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   fail_count,
	output int   pending
);

	rsp_t        expected_q[$];
	logic [31:0] target_reg;

	function automatic logic [31:0] select_src(logic [31:0] dec, logic [31:0] file,
		logic [31:0] mem, logic [1:0] route, logic stall2);
		if (route == ROUTE_FILE) return file;
		if (route == ROUTE_MEM) return stall2 ? file : mem;
		return dec;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		fail_count++;
	endtask

	task automatic execute_beat(req_t r);
		logic [31:0] a, b, imm, res, ea, qa, qb, q;
		logic        taken, dz;
		rsp_t        e;
		a = select_src(r.rs_decoded, r.rs_file_value, r.rs_mem_value, r.rs_route,
			r.stall_two_ago);
		b = select_src(r.rt_decoded, r.rt_file_value, r.rt_mem_value, r.rt_route,
			r.stall_two_ago);
		imm = r.immediate;
		res = '0;
		ea = '0;
		taken = 0;
		dz = 0;
		case (r.func)
			OP_ADD:  res = a + b;
			OP_SUB:  res = a - b;
			OP_MULT: res = a * b;
			OP_DIV: begin
				if (b == 0) dz = 1;
				else begin
					// magnitude divide then fix sign; min / -1 wraps
					qa = a[31] ? -a : a;
					qb = b[31] ? -b : b;
					q = qa / qb;
					res = (a[31] != b[31]) ? -q : q;
				end
			end
			OP_LW, OP_SW: ea = a + imm;
			OP_ADDI: res = a + imm;
			OP_BGTZ: taken = !a[31] && a != 0;
			OP_BLEZ: taken = a[31] || a == 0;
			OP_BEQ:  taken = a == b;
			OP_J:    taken = 1;
			default: ;
		endcase
		if (taken) target_reg = imm;
		e.result_value = res;
		e.effective_address = ea;
		e.branch_taken = taken;
		e.branch_target = target_reg;
		e.divide_by_zero = dz;
		expected_q.push_back(e);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			expected_q.delete();
			target_reg = '0;
			fail_count = 0;
		end else begin
			if (req_valid && !req_stall && !req.bubble) execute_beat(req);
			if (rsp_valid && !rsp_stall) begin
				if (expected_q.size() == 0) begin
					report("unexpected result beat", rsp.result_value, '0);
				end else begin
					e = expected_q.pop_front();
					if (rsp.result_value !== e.result_value)
						report("result_value", rsp.result_value, e.result_value);
					if (rsp.effective_address !== e.effective_address)
						report("effective_address", rsp.effective_address,
							e.effective_address);
					if (rsp.branch_taken !== e.branch_taken)
						report("branch_taken", rsp.branch_taken, e.branch_taken);
					if (rsp.branch_target !== e.branch_target)
						report("branch_target", rsp.branch_target, e.branch_target);
					if (rsp.divide_by_zero !== e.divide_by_zero)
						report("divide_by_zero", rsp.divide_by_zero, e.divide_by_zero);
				end
			end
		end
		pending = expected_q.size();
	end

endmodule

// ===== tb/sv/tb_mips_execute_alu_branch.sv =====
// Testbench top for the execute stage: stimulus, idling and the verdict.
`timescale 1ns / 1ps
module tb_mips_execute_alu_branch;
	import meab_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1;
	rsp_t rsp;
	int   fail_count;
	int   pending;
	int   cycle_count = 0;
	bit   long_hold = 0;  // receiver holds off a long stretch
	bit   sink_go = 0;

	always #1 clk = ~clk;

	mips_execute_alu_branch dut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	mips_execute_alu_branch_checker checker_i (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.fail_count(fail_count), .pending(pending)
	);

	// Watchdog: ends the run as a failure long after the pipe and its stalls would need.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 200000) begin
			$display("status: fail");
			$finish;
		end
	end

	// Corner operand values.
	function automatic logic [31:0] corner_val();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'h0000_0001;
			2: return 32'hFFFF_FFFF;
			3: return 32'h8000_0000;
			4: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic req_t rand_beat();
		req_t r;
		r.func          = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
			: 4'($urandom_range(OP_ADD, OP_J));
		r.rs_decoded    = corner_val();
		r.rs_file_value = corner_val();
		r.rs_mem_value  = corner_val();
		r.rs_route      = 2'($urandom_range(0, 3));
		r.rt_decoded    = corner_val();
		r.rt_file_value = corner_val();
		r.rt_mem_value  = corner_val();
		r.rt_route      = 2'($urandom_range(0, 3));
		r.immediate     = corner_val();
		r.stall_two_ago = 1'($urandom_range(0, 1));
		r.bubble        = ($urandom_range(0, 9) == 0);
		return r;
	endfunction

	// Drive one beat with a random lead gap (or none in burst mode).
	// Starts and ends at a falling edge; valid stays up between gapless beats.
	task automatic send_beat(req_t r, bit burst);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			req_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		req <= r;
		req_valid <= 1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Receiver: random stall per beat, with bursts of no stall and one long hold.
	initial begin
		int wait_n;
		bit hold_done;
		hold_done = 0;
		wait (sink_go);
		forever begin
			if (long_hold && !hold_done) begin
				wait_n = 120;
				hold_done = 1;
			end else begin
				wait_n = (cycle_count % 3000 < 600) ? 0 : $urandom_range(0, 15);
			end
			if (wait_n > 0) begin
				rsp_stall <= 1;
				repeat (wait_n) @(negedge clk);
			end
			rsp_stall <= 0;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	initial begin
		req_t r;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		sink_go = 1;
		// Directed: every operation, overflow, zero divisor, routes, bubble.
		for (int f = 0; f <= 15; f++) begin
			r = rand_beat();
			r.func = 4'(f);
			r.bubble = 0;
			r.rs_route = 2'(f % 4);
			r.rt_route = 2'((f + 1) % 4);
			r.stall_two_ago = f[0];
			send_beat(r, 0);
		end
		r = '0; r.func = OP_DIV; r.rs_decoded = 32'h8000_0000;
		r.rt_decoded = 32'hFFFF_FFFF; send_beat(r, 0);
		r.rt_decoded = 0; send_beat(r, 0);
		r = '0; r.func = OP_ADD; r.rs_decoded = 32'h7FFF_FFFF;
		r.rt_decoded = 1; send_beat(r, 0);
		r.func = OP_MULT; r.rt_decoded = 32'h7FFF_FFFF; send_beat(r, 0);
		r = '0; r.func = OP_J; r.immediate = 32'hFFFF_FFFF; send_beat(r, 0);
		r.bubble = 1; r.immediate = 32'h1234_5678; send_beat(r, 0);
		r = '0; r.func = OP_BEQ; r.rs_route = ROUTE_MEM; r.rt_route = ROUTE_MEM;
		r.rs_mem_value = 5; r.rt_mem_value = 5; r.immediate = 32'h8000_0000;
		send_beat(r, 0);
		// Random: a back-to-back burst during the long receiver hold.
		for (int i = 0; i < 900; i++) begin
			if (i == 300) long_hold = 1;
			send_beat(rand_beat(), (i >= 300 && i < 400) || (i % 200 < 30));
		end
		req_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule
